>>> hw/rtl/fibsq_pkg.sv
// shared types and constants for the frame indexed burst slot queue
package fibsq_pkg;

    localparam int TS_W        = 3;
    localparam int FRAME_W     = 22;
    localparam int LEN_W       = 9;
    localparam int STATUS_W    = 3;
    localparam int IDX_OUT_W   = 7;
    localparam int PURGE_OUT_W = 8;
    localparam int CNT_W       = 32;
    localparam int HYP_W       = 23;
    localparam int DIST_W      = 24;

    localparam logic [LEN_W-1:0] MAX_BURST_LEN = LEN_W'(296);

    localparam int DEF_NUM_TIMESLOTS   = 8;
    localparam int DEF_SLOTS_PER_QUEUE = 128;
    localparam int DEF_HYPERFRAME_LEN  = 2715648;

    typedef enum logic [STATUS_W-1:0] {
        ST_DUP     = 3'd0,
        ST_FREE    = 3'd1,
        ST_EVICT   = 3'd2,
        ST_MATCH   = 3'd3,
        ST_NOMATCH = 3'd4,
        ST_REJECT  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
        logic [LEN_W-1:0]   len;
    } t_slot_word;

endpackage

>>> hw/rtl/fibsq_store.sv
// slot memory with one write and one registered read port, cleared by a sweep after reset
module fibsq_store #(
    parameter int DEPTH  = fibsq_pkg::DEF_NUM_TIMESLOTS * fibsq_pkg::DEF_SLOTS_PER_QUEUE,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_en,
    input  logic [ADDR_W-1:0]      i_rd_addr,
    output fibsq_pkg::t_slot_word  o_rd_data,
    input  logic                   i_wr_en,
    input  logic [ADDR_W-1:0]      i_wr_addr,
    input  fibsq_pkg::t_slot_word  i_wr_data,
    output logic                   o_busy
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    fibsq_pkg::t_slot_word r_mem [DEPTH];
    fibsq_pkg::t_slot_word r_rd_data;
    logic                  r_clr_active;
    logic [ADDR_W-1:0]     r_clr_addr;

    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    fibsq_pkg::t_slot_word wr_data;

    always_comb begin
        if (r_clr_active) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_wr_en;
            wr_addr = i_wr_addr;
            wr_data = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_active;

endmodule

>>> hw/rtl/frame_indexed_burst_slot_queue_top.sv
// top level of the frame indexed burst slot queue: scan sequencer, counters and result register
//
// Every accepted transaction that is not rejected reads the SLOTS_PER_QUEUE slots of the addressed
// timeslot from the slot memory, one slot per cycle through a read, distance and decide pipeline,
// then an enqueue writes its frame into a free or evicted slot and a consuming take clears the
// slot it matched; an enqueue that hits an existing frame rewrites that slot and ends early, and a
// rejected item (bad timeslot or frame at or above the hyperframe) skips the scan. The next item
// is accepted only once the previous one has finished. The single read port of the slot memory
// sets the pace of the scan. A new item can be accepted while the previous result is still waiting
// on the output; a finished result that finds the output register still full waits until it drains.
// After reset the slot memory is cleared by a sweep over all NUM_TIMESLOTS * SLOTS_PER_QUEUE
// entries (1024 by default) during which o_ready stays low.
module frame_indexed_burst_slot_queue_top #(
    parameter int NUM_TIMESLOTS   = fibsq_pkg::DEF_NUM_TIMESLOTS,
    parameter int SLOTS_PER_QUEUE = fibsq_pkg::DEF_SLOTS_PER_QUEUE,
    parameter int HYPERFRAME_LEN  = fibsq_pkg::DEF_HYPERFRAME_LEN
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_kind,
    input  logic [fibsq_pkg::TS_W-1:0]          i_timeslot,
    input  logic [fibsq_pkg::FRAME_W-1:0]       i_frame_number,
    input  logic [fibsq_pkg::LEN_W-1:0]         i_burst_len,
    input  logic                                i_consume,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [fibsq_pkg::STATUS_W-1:0]      o_status,
    output logic [fibsq_pkg::IDX_OUT_W-1:0]     o_slot_index,
    output logic [fibsq_pkg::LEN_W-1:0]         o_matched_len,
    output logic [fibsq_pkg::FRAME_W-1:0]       o_evicted_frame,
    output logic [fibsq_pkg::PURGE_OUT_W-1:0]   o_purged_count,
    output logic [fibsq_pkg::CNT_W-1:0]         o_full_drops_total,
    output logic [fibsq_pkg::CNT_W-1:0]         o_stale_drops_total
);

    localparam int DEPTH  = NUM_TIMESLOTS * SLOTS_PER_QUEUE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SLOT_W = $clog2(SLOTS_PER_QUEUE);
    localparam int DIST_W = fibsq_pkg::DIST_W;

    localparam logic [SLOT_W:0]   SLOT_COUNT = (SLOT_W + 1)'(SLOTS_PER_QUEUE);
    localparam logic [SLOT_W-1:0] LAST_IDX   = SLOT_W'(SLOTS_PER_QUEUE - 1);
    localparam logic [fibsq_pkg::HYP_W-1:0] HYP_LIMIT = fibsq_pkg::HYP_W'(HYPERFRAME_LEN);
    localparam logic signed [DIST_W-1:0] HYP_S  = DIST_W'(HYPERFRAME_LEN);
    localparam logic signed [DIST_W-1:0] HALF_S = DIST_W'(HYPERFRAME_LEN / 2);
    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W - 1){1'b1}}};
    localparam logic [fibsq_pkg::CNT_W-1:0] CNT_MAX = '1;

    fibsq_pkg::t_state r_state;
    fibsq_pkg::t_state n_state;

    // accepted transaction
    logic                             r_kind;
    logic                             r_consume;
    logic [ADDR_W-1:0]                r_base;
    logic [fibsq_pkg::FRAME_W-1:0]    r_fn;
    logic [fibsq_pkg::LEN_W-1:0]      r_len;

    // scan pipeline
    logic [SLOT_W:0]                  r_rd_cnt;
    logic                             r_s1_live;
    logic [SLOT_W-1:0]                r_s1_idx;
    logic                             r_s2_live;
    logic [SLOT_W-1:0]                r_s2_idx;
    fibsq_pkg::t_slot_word            r_s2_word;
    logic signed [DIST_W-1:0]         r_s2_dist;

    // scan tracking
    logic                             r_have_free;
    logic [SLOT_W-1:0]                r_free_idx;
    logic signed [DIST_W-1:0]         r_old_dist;
    logic [SLOT_W-1:0]                r_old_idx;
    logic [fibsq_pkg::FRAME_W-1:0]    r_old_frame;
    logic                             r_found;
    logic [SLOT_W-1:0]                r_match_idx;
    logic [fibsq_pkg::LEN_W-1:0]      r_match_len;
    logic [SLOT_W:0]                  r_purged;

    // result of the current transaction
    fibsq_pkg::t_status               r_res_status;
    logic [SLOT_W-1:0]                r_res_idx;
    logic [fibsq_pkg::LEN_W-1:0]      r_res_mlen;
    logic [fibsq_pkg::FRAME_W-1:0]    r_res_evf;

    logic [fibsq_pkg::CNT_W-1:0]      r_full_cnt;
    logic [fibsq_pkg::CNT_W-1:0]      r_stale_cnt;

    // output register
    logic                             r_out_valid;
    logic [fibsq_pkg::STATUS_W-1:0]   r_out_status;
    logic [fibsq_pkg::IDX_OUT_W-1:0]  r_out_idx;
    logic [fibsq_pkg::LEN_W-1:0]      r_out_mlen;
    logic [fibsq_pkg::FRAME_W-1:0]    r_out_evf;
    logic [fibsq_pkg::PURGE_OUT_W-1:0] r_out_purged;
    logic [fibsq_pkg::CNT_W-1:0]      r_out_full;
    logic [fibsq_pkg::CNT_W-1:0]      r_out_stale;

    // memory interface
    logic                             rd_en;
    logic [ADDR_W-1:0]                rd_addr;
    fibsq_pkg::t_slot_word            rd_data;
    logic                             wr_en;
    logic [ADDR_W-1:0]                wr_addr;
    fibsq_pkg::t_slot_word            wr_data;
    logic                             store_busy;

    logic                             in_take;
    logic                             in_bad;
    logic                             out_load;
    logic                             s2_act;
    logic                             s2_dup;
    logic                             s2_free;
    logic                             s2_older;
    logic                             s2_match;
    logic                             s2_purge;
    logic                             s2_last;
    logic signed [DIST_W-1:0]         raw_dist;
    logic signed [DIST_W-1:0]         wrap_dist;
    logic [fibsq_pkg::LEN_W-1:0]      in_len_sat;

    fibsq_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_busy    (store_busy)
    );

    // hyperframe-wrapped distance of the slot just read
    always_comb begin
        raw_dist = $signed(DIST_W'(rd_data.frame)) - $signed(DIST_W'(r_fn));
        if (raw_dist > HALF_S) begin
            wrap_dist = raw_dist - HYP_S;
        end else if (raw_dist <= -HALF_S) begin
            wrap_dist = raw_dist + HYP_S;
        end else begin
            wrap_dist = raw_dist;
        end
    end

    assign in_bad = ({1'b0, i_frame_number} >= HYP_LIMIT)
                 || ({1'b0, i_timeslot} >= (fibsq_pkg::TS_W + 1)'(NUM_TIMESLOTS));
    assign in_len_sat = (i_burst_len > fibsq_pkg::MAX_BURST_LEN) ? fibsq_pkg::MAX_BURST_LEN
                                                                   : i_burst_len;

    always_comb begin
        s2_act   = (r_state == fibsq_pkg::S_SCAN) && r_s2_live;
        s2_dup   = s2_act && !r_kind && r_s2_word.valid && (r_s2_dist == '0);
        s2_free  = s2_act && !r_kind && !r_s2_word.valid;
        s2_older = s2_act && !r_kind && r_s2_word.valid && (r_s2_dist != '0)
                && (r_s2_dist < r_old_dist);
        s2_match = s2_act && r_kind && r_s2_word.valid && (r_s2_dist == '0);
        s2_purge = s2_act && r_kind && r_s2_word.valid && (r_s2_dist < 0);
        s2_last  = s2_act && (r_s2_idx == LAST_IDX);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fibsq_pkg::S_IDLE: begin
                if (in_take) begin
                    n_state = in_bad ? fibsq_pkg::S_DONE : fibsq_pkg::S_SCAN;
                end
            end
            fibsq_pkg::S_SCAN: begin
                if (s2_dup) begin
                    n_state = fibsq_pkg::S_DONE;
                end else if (s2_last) begin
                    n_state = fibsq_pkg::S_FINISH;
                end
            end
            fibsq_pkg::S_FINISH: begin
                n_state = fibsq_pkg::S_DONE;
            end
            fibsq_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = fibsq_pkg::S_IDLE;
                end
            end
            default: n_state = fibsq_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ready  = 1'b0;
        out_load = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = r_base + ADDR_W'(r_rd_cnt[SLOT_W-1:0]);
        wr_en    = 1'b0;
        wr_addr  = r_base + ADDR_W'(r_s2_idx);
        wr_data  = r_s2_word;
        unique case (r_state)
            fibsq_pkg::S_IDLE: begin
                o_ready = !store_busy;
            end
            fibsq_pkg::S_SCAN: begin
                rd_en = (r_rd_cnt < SLOT_COUNT);
                if (s2_dup) begin
                    wr_en   = 1'b1;
                    wr_data = '{valid: 1'b1, frame: r_fn, len: r_len};
                end else if (s2_purge) begin
                    wr_en         = 1'b1;
                    wr_data.valid = 1'b0;
                end
            end
            fibsq_pkg::S_FINISH: begin
                if (!r_kind) begin
                    wr_en   = 1'b1;
                    wr_addr = r_base + ADDR_W'(r_have_free ? r_free_idx : r_old_idx);
                    wr_data = '{valid: 1'b1, frame: r_fn, len: r_len};
                end else begin
                    wr_en   = r_found && r_consume;
                    wr_addr = r_base + ADDR_W'(r_match_idx);
                    wr_data = '{valid: 1'b0, frame: r_fn, len: r_match_len};
                end
            end
            fibsq_pkg::S_DONE: begin
                out_load = !r_out_valid || i_ready;
            end
            default: ;
        endcase
    end

    assign in_take = i_valid && o_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fibsq_pkg::S_IDLE;
            r_s1_live   <= 1'b0;
            r_s2_live   <= 1'b0;
            r_rd_cnt    <= '0;
            r_out_valid <= 1'b0;
            r_full_cnt  <= '0;
            r_stale_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (in_take) begin
                r_rd_cnt  <= '0;
                r_s1_live <= 1'b0;
                r_s2_live <= 1'b0;
            end else begin
                if (rd_en) begin
                    r_rd_cnt <= r_rd_cnt + 1'b1;
                end
                r_s1_live <= rd_en;
                r_s2_live <= r_s1_live;
            end
            if (s2_purge && r_stale_cnt != CNT_MAX) begin
                r_stale_cnt <= r_stale_cnt + 1'b1;
            end
            if (r_state == fibsq_pkg::S_FINISH && !r_kind && !r_have_free
                && r_full_cnt != CNT_MAX) begin
                r_full_cnt <= r_full_cnt + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind       <= i_kind;
            r_consume    <= i_consume;
            r_fn         <= i_frame_number;
            r_len        <= in_len_sat;
            r_base       <= ADDR_W'(i_timeslot * SLOTS_PER_QUEUE);
            r_have_free  <= 1'b0;
            r_old_dist   <= DIST_MAX;
            r_found      <= 1'b0;
            r_purged     <= '0;
            r_res_status <= fibsq_pkg::ST_REJECT;
            r_res_idx    <= '0;
            r_res_mlen   <= '0;
            r_res_evf    <= '0;
        end

        r_s1_idx  <= r_rd_cnt[SLOT_W-1:0];
        r_s2_idx  <= r_s1_idx;
        r_s2_word <= rd_data;
        r_s2_dist <= wrap_dist;

        if (s2_dup) begin
            r_res_status <= fibsq_pkg::ST_DUP;
            r_res_idx    <= r_s2_idx;
        end
        if (s2_free && !r_have_free) begin
            r_have_free <= 1'b1;
            r_free_idx  <= r_s2_idx;
        end
        if (s2_older) begin
            r_old_dist  <= r_s2_dist;
            r_old_idx   <= r_s2_idx;
            r_old_frame <= r_s2_word.frame;
        end
        if (s2_match) begin
            r_found     <= 1'b1;
            r_match_idx <= r_s2_idx;
            r_match_len <= r_s2_word.len;
        end
        if (s2_purge) begin
            r_purged <= r_purged + 1'b1;
        end

        if (r_state == fibsq_pkg::S_FINISH) begin
            if (!r_kind) begin
                if (r_have_free) begin
                    r_res_status <= fibsq_pkg::ST_FREE;
                    r_res_idx    <= r_free_idx;
                end else begin
                    r_res_status <= fibsq_pkg::ST_EVICT;
                    r_res_idx    <= r_old_idx;
                    r_res_evf    <= r_old_frame;
                end
            end else if (r_found) begin
                r_res_status <= fibsq_pkg::ST_MATCH;
                r_res_idx    <= r_match_idx;
                r_res_mlen   <= r_match_len;
            end else begin
                r_res_status <= fibsq_pkg::ST_NOMATCH;
            end
        end

        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_idx    <= fibsq_pkg::IDX_OUT_W'(r_res_idx);
            r_out_mlen   <= r_res_mlen;
            r_out_evf    <= r_res_evf;
            r_out_purged <= fibsq_pkg::PURGE_OUT_W'(r_purged);
            r_out_full   <= r_full_cnt;
            r_out_stale  <= r_stale_cnt;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_status            = r_out_status;
    assign o_slot_index        = r_out_idx;
    assign o_matched_len       = r_out_mlen;
    assign o_evicted_frame     = r_out_evf;
    assign o_purged_count      = r_out_purged;
    assign o_full_drops_total  = r_out_full;
    assign o_stale_drops_total = r_out_stale;

endmodule

>>> tb/sv/tb_frame_indexed_burst_slot_queue_top.sv
// self-checking testbench for the frame indexed burst slot queue top level
module tb_frame_indexed_burst_slot_queue_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_ENQUEUE = 1'b0;
    localparam logic KIND_TAKE    = 1'b1;

    localparam int TS_W        = fibsq_pkg::TS_W;
    localparam int FRAME_W     = fibsq_pkg::FRAME_W;
    localparam int LEN_W       = fibsq_pkg::LEN_W;
    localparam int STATUS_W    = fibsq_pkg::STATUS_W;
    localparam int IDX_OUT_W   = fibsq_pkg::IDX_OUT_W;
    localparam int PURGE_OUT_W = fibsq_pkg::PURGE_OUT_W;
    localparam int CNT_W       = fibsq_pkg::CNT_W;

    localparam int N_TS       = fibsq_pkg::DEF_NUM_TIMESLOTS;
    localparam int N_SLOTS    = fibsq_pkg::DEF_SLOTS_PER_QUEUE;
    localparam int HYPER_LEN  = fibsq_pkg::DEF_HYPERFRAME_LEN;
    localparam int HALF_HYPER = HYPER_LEN / 2;
    localparam int FRAME_MAX  = (1 << FRAME_W) - 1;
    localparam int LEN_MAX    = (1 << LEN_W) - 1;

    typedef struct packed {
        fibsq_pkg::t_status     status;
        logic [IDX_OUT_W-1:0]   slot;
        logic [LEN_W-1:0]       mlen;
        logic [FRAME_W-1:0]     evicted;
        logic [PURGE_OUT_W-1:0] purged;
        logic [CNT_W-1:0]       full_total;
        logic [CNT_W-1:0]       stale_total;
    } t_slot_result;

    logic                   i_clk;
    logic                   i_rst_n        = 1'b0;
    logic                   i_valid        = 1'b0;
    logic                   i_kind         = 1'b0;
    logic [TS_W-1:0]        i_timeslot     = '0;
    logic [FRAME_W-1:0]     i_frame_number = '0;
    logic [LEN_W-1:0]       i_burst_len    = '0;
    logic                   i_consume      = 1'b0;
    logic                   i_ready        = 1'b0;
    logic                   o_ready;
    logic                   o_valid;
    logic [STATUS_W-1:0]    o_status;
    logic [IDX_OUT_W-1:0]   o_slot_index;
    logic [LEN_W-1:0]       o_matched_len;
    logic [FRAME_W-1:0]     o_evicted_frame;
    logic [PURGE_OUT_W-1:0] o_purged_count;
    logic [CNT_W-1:0]       o_full_drops_total;
    logic [CNT_W-1:0]       o_stale_drops_total;

    // queue occupancy as the block should hold it
    logic               occupied [N_TS][N_SLOTS];
    logic [FRAME_W-1:0] frame_of [N_TS][N_SLOTS];
    logic [LEN_W-1:0]   len_of   [N_TS][N_SLOTS];
    logic [CNT_W-1:0]   full_drops  = '0;
    logic [CNT_W-1:0]   stale_drops = '0;

    t_slot_result pending_results [$];
    int unsigned  cur_fn [N_TS];
    int           status_seen [6];
    int           snd_idle  = 0;
    int           rcv_idle  = 0;
    int           err_count = 0;
    int           n_sent    = 0;
    int           n_checked = 0;

    frame_indexed_burst_slot_queue_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_kind              (i_kind),
        .i_timeslot          (i_timeslot),
        .i_frame_number      (i_frame_number),
        .i_burst_len         (i_burst_len),
        .i_consume           (i_consume),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_status            (o_status),
        .o_slot_index        (o_slot_index),
        .o_matched_len       (o_matched_len),
        .o_evicted_frame     (o_evicted_frame),
        .o_purged_count      (o_purged_count),
        .o_full_drops_total  (o_full_drops_total),
        .o_stale_drops_total (o_stale_drops_total)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int wrap_dist(int unsigned slot_fn, int unsigned cur);
        int d;
        d = int'(slot_fn) - int'(cur);
        if (d > HALF_HYPER) begin
            d -= HYPER_LEN;
        end else if (d <= -HALF_HYPER) begin
            d += HYPER_LEN;
        end
        return d;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // apply one operation to the queue copy and return what the block must answer
    function automatic t_slot_result predict_slot_op(logic kind, logic [TS_W-1:0] ts,
                                                     logic [FRAME_W-1:0] fn,
                                                     logic [LEN_W-1:0] len, logic cons);
        t_slot_result     r;
        logic             have_free;
        logic             done;
        logic             found;
        int               free_i;
        int               old_i;
        int               old_d;
        int               d;
        int               idx;
        int               purged;
        logic [LEN_W-1:0] clen;
        r         = '0;
        r.status  = fibsq_pkg::ST_REJECT;
        have_free = 1'b0;
        done      = 1'b0;
        found     = 1'b0;
        free_i    = 0;
        old_i     = 0;
        old_d     = 32'h7fff_ffff;
        idx       = 0;
        purged    = 0;
        clen      = (len > fibsq_pkg::MAX_BURST_LEN) ? fibsq_pkg::MAX_BURST_LEN : len;
        if (ts < N_TS && fn < HYPER_LEN) begin
            if (kind == KIND_ENQUEUE) begin
                for (int i = 0; i < N_SLOTS && !done; i++) begin
                    if (occupied[ts][i] && frame_of[ts][i] == fn) begin
                        len_of[ts][i] = clen;
                        r.status      = fibsq_pkg::ST_DUP;
                        idx           = i;
                        done          = 1'b1;
                    end else if (!occupied[ts][i]) begin
                        if (!have_free) begin
                            have_free = 1'b1;
                            free_i    = i;
                        end
                    end else begin
                        d = wrap_dist(frame_of[ts][i], fn);
                        if (d < old_d) begin
                            old_d = d;
                            old_i = i;
                        end
                    end
                end
                if (!done) begin
                    if (have_free) begin
                        idx      = free_i;
                        r.status = fibsq_pkg::ST_FREE;
                    end else begin
                        idx        = old_i;
                        r.status   = fibsq_pkg::ST_EVICT;
                        r.evicted  = frame_of[ts][old_i];
                        full_drops = sat_inc(full_drops);
                    end
                    occupied[ts][idx] = 1'b1;
                    frame_of[ts][idx] = fn;
                    len_of[ts][idx]   = clen;
                end
            end else begin
                r.status = fibsq_pkg::ST_NOMATCH;
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (occupied[ts][i]) begin
                        d = wrap_dist(frame_of[ts][i], fn);
                        if (d == 0) begin
                            found = 1'b1;
                            idx   = i;
                        end else if (d < 0) begin
                            occupied[ts][i] = 1'b0;
                            purged++;
                            stale_drops = sat_inc(stale_drops);
                        end
                    end
                end
                if (found) begin
                    r.status = fibsq_pkg::ST_MATCH;
                    r.mlen   = len_of[ts][idx];
                    if (cons) begin
                        occupied[ts][idx] = 1'b0;
                    end
                end
            end
        end
        r.slot        = idx[IDX_OUT_W-1:0];
        r.purged      = purged[PURGE_OUT_W-1:0];
        r.full_total  = full_drops;
        r.stale_total = stale_drops;
        return r;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("result %0d %s got %0d expected %0d",
                                   n_checked, name, got, want));
        end
    endtask

    task automatic check_result();
        t_slot_result want;
        if (pending_results.size() == 0) begin
            report_error($sformatf("result transaction with nothing expected, status %0d",
                                   o_status));
            return;
        end
        want = pending_results.pop_front();
        n_checked++;
        check_field("status", o_status, want.status);
        check_field("slot_index", o_slot_index, want.slot);
        check_field("matched_len", o_matched_len, want.mlen);
        check_field("evicted_frame", o_evicted_frame, want.evicted);
        check_field("purged_count", o_purged_count, want.purged);
        check_field("full_drops_total", o_full_drops_total, want.full_total);
        check_field("stale_drops_total", o_stale_drops_total, want.stale_total);
    endtask

    // result side: check each accepted transaction, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            check_result();
        end
        i_ready <= ($urandom_range(99, 0) >= rcv_idle);
    end

    task automatic send_op(logic kind, int unsigned ts, int unsigned fn, int unsigned len,
                           logic cons);
        t_slot_result r;
        while ($urandom_range(99, 0) < snd_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_kind         <= kind;
        i_timeslot     <= ts[TS_W-1:0];
        i_frame_number <= fn[FRAME_W-1:0];
        i_burst_len    <= len[LEN_W-1:0];
        i_consume      <= cons;
        @(posedge i_clk);
        while (o_ready !== 1'b1) begin
            @(posedge i_clk);
        end
        r = predict_slot_op(kind, ts[TS_W-1:0], fn[FRAME_W-1:0], len[LEN_W-1:0], cons);
        pending_results.push_back(r);
        status_seen[r.status]++;
        n_sent++;
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_directed();
        // empty queue, overwrite with overlong length, take with and without consume
        send_op(KIND_TAKE, 0, 0, 0, 1'b1);
        send_op(KIND_ENQUEUE, 0, 0, 0, 1'b0);
        send_op(KIND_ENQUEUE, 0, 0, LEN_MAX, 1'b1);
        send_op(KIND_TAKE, 0, 0, 0, 1'b0);
        send_op(KIND_TAKE, 0, 0, 0, 1'b1);
        send_op(KIND_TAKE, 0, 0, 0, 1'b1);
        // stale entries just behind the hyperframe wrap
        send_op(KIND_ENQUEUE, 7, HYPER_LEN - 1, 296, 1'b0);
        send_op(KIND_ENQUEUE, 7, 1, 297, 1'b0);
        send_op(KIND_ENQUEUE, 7, HYPER_LEN - 2, 100, 1'b0);
        send_op(KIND_TAKE, 7, 0, 0, 1'b1);
        send_op(KIND_TAKE, 7, 1, 0, 1'b1);
        // frames out of range
        send_op(KIND_ENQUEUE, 7, HYPER_LEN, 5, 1'b0);
        send_op(KIND_ENQUEUE, 7, FRAME_MAX, LEN_MAX, 1'b1);
        send_op(KIND_TAKE, 3, HYPER_LEN, 0, 1'b1);
        // distance exactly half a hyperframe stays in the future, one more is past
        send_op(KIND_ENQUEUE, 5, 0, 1, 1'b0);
        send_op(KIND_ENQUEUE, 5, HALF_HYPER, 2, 1'b0);
        send_op(KIND_ENQUEUE, 5, HALF_HYPER + 1, 3, 1'b0);
        send_op(KIND_TAKE, 5, 0, 0, 1'b0);
        send_op(KIND_TAKE, 5, HALF_HYPER, 0, 1'b1);
        send_op(KIND_TAKE, 5, HALF_HYPER, 0, 1'b1);
    endtask

    // fill one timeslot past capacity, then age everything out
    task automatic test_queue_overflow(int unsigned ts, int unsigned base, bit mid_take);
        for (int k = 0; k < 170; k++) begin
            send_op(KIND_ENQUEUE, ts, (base + $urandom_range(2047, 0)) % HYPER_LEN,
                    $urandom_range(LEN_MAX, 0), $urandom_range(1, 0) != 0);
        end
        if (mid_take) begin
            send_op(KIND_TAKE, ts, (base + 1024) % HYPER_LEN, $urandom_range(LEN_MAX, 0),
                    $urandom_range(1, 0) != 0);
        end
        send_op(KIND_TAKE, ts, (base + 4096) % HYPER_LEN, $urandom_range(LEN_MAX, 0),
                $urandom_range(1, 0) != 0);
    endtask

    // bursts arrive a little ahead of a per-timeslot current frame that takes advance
    task automatic test_burst_stream(int n);
        int unsigned ts;
        int unsigned pick;
        int unsigned len;
        for (int k = 0; k < n; k++) begin
            ts   = $urandom_range(N_TS - 1, 0);
            pick = $urandom_range(99, 0);
            len  = ($urandom_range(9, 0) == 0) ? $urandom_range(LEN_MAX, 297)
                                                : $urandom_range(296, 0);
            if (pick < 50) begin
                send_op(KIND_ENQUEUE, ts, (cur_fn[ts] + $urandom_range(24, 0)) % HYPER_LEN,
                        len, $urandom_range(1, 0) != 0);
            end else if (pick < 85) begin
                send_op(KIND_TAKE, ts, cur_fn[ts], len, $urandom_range(3, 0) != 0);
                cur_fn[ts] = (cur_fn[ts] + $urandom_range(2, 0)) % HYPER_LEN;
            end else if (pick < 90) begin
                // late burst, already behind the current frame
                send_op(KIND_ENQUEUE, ts,
                        (cur_fn[ts] + HYPER_LEN - $urandom_range(30, 1)) % HYPER_LEN,
                        len, $urandom_range(1, 0) != 0);
            end else if (pick < 93) begin
                cur_fn[ts] = $urandom_range(HYPER_LEN - 1, 0);
                send_op(KIND_TAKE, ts, cur_fn[ts], len, $urandom_range(1, 0) != 0);
            end else begin
                send_op($urandom_range(1, 0) != 0, ts, $urandom_range(FRAME_MAX, 0),
                        $urandom_range(LEN_MAX, 0), $urandom_range(1, 0) != 0);
            end
        end
    endtask

    initial begin
        foreach (occupied[t, s]) begin
            occupied[t][s] = 1'b0;
        end
        foreach (cur_fn[t]) begin
            cur_fn[t] = (t % 2 == 1) ? $urandom_range(HYPER_LEN - 1, HYPER_LEN - 40)
                                     : $urandom_range(HYPER_LEN - 1, 0);
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle = 35;
        rcv_idle = 46;
        test_directed();
        pause_until_drained();
        test_queue_overflow(2, $urandom_range(HYPER_LEN - 1, 0), 1'b0);

        snd_idle = 46;
        rcv_idle = 35;
        test_burst_stream(380);
        pause_until_drained();

        snd_idle = 0;
        rcv_idle = 0;
        test_queue_overflow(6, HYPER_LEN - 1000, 1'b1);
        test_burst_stream(380);

        pause_until_drained();
        repeat (200) @(posedge i_clk);

        $display("%0d operations, %0d results checked: %0d overwrites, %0d free-slot writes,",
                 n_sent, n_checked, status_seen[fibsq_pkg::ST_DUP],
                 status_seen[fibsq_pkg::ST_FREE]);
        $display("%0d evictions; takes: %0d matches, %0d misses; %0d rejects; drops full %0d stale %0d",
                 status_seen[fibsq_pkg::ST_EVICT], status_seen[fibsq_pkg::ST_MATCH],
                 status_seen[fibsq_pkg::ST_NOMATCH], status_seen[fibsq_pkg::ST_REJECT],
                 full_drops, stale_drops);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("Verification failed");
        $finish;
    end

endmodule
